@@ sv/basic_line_tokenizer_defines.svh @@
// assertion macros used by the tokenizer port checker
`ifndef BASIC_LINE_TOKENIZER_DEFINES_SVH
`define BASIC_LINE_TOKENIZER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BLT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/blt_pkg.sv @@
// types, constants and lookup functions of the line tokenizer
`timescale 1ns / 1ps
package blt_pkg;

  localparam int WORD_MAX = 32;
  localparam int ADDR_W   = $clog2(WORD_MAX);
  localparam int LEN_W    = $clog2(WORD_MAX + 1);
  localparam int KEY_MAX  = 5;
  localparam int KEY_W    = 8 * KEY_MAX;
  localparam int NUM_W    = 63;
  localparam int CH_W     = 8;
  localparam int TDATA_W  = 80;
  localparam int NPH      = 5;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  localparam logic [2:0] K_KEY   = 3'd0;
  localparam logic [2:0] K_OP    = 3'd1;
  localparam logic [2:0] K_CMP   = 3'd2;
  localparam logic [2:0] K_CMD   = 3'd3;
  localparam logic [2:0] K_CONST = 3'd4;
  localparam logic [2:0] K_IDENT = 3'd5;
  localparam logic [2:0] K_STR   = 3'd6;
  localparam logic [2:0] K_ERR   = 3'd7;

  localparam logic [3:0] KEY_REM   = 4'd0;
  localparam logic [3:0] KEY_LET   = 4'd1;
  localparam logic [3:0] KEY_PRINT = 4'd2;
  localparam logic [3:0] KEY_INPUT = 4'd3;
  localparam logic [3:0] KEY_GOTO  = 4'd4;
  localparam logic [3:0] KEY_IF    = 4'd5;
  localparam logic [3:0] KEY_THEN  = 4'd6;
  localparam logic [3:0] KEY_END   = 4'd7;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_NEG  = 4'd2;
  localparam logic [3:0] OP_MUL  = 4'd3;
  localparam logic [3:0] OP_POW  = 4'd4;
  localparam logic [3:0] OP_DIV  = 4'd5;
  localparam logic [3:0] OP_LPAR = 4'd6;
  localparam logic [3:0] OP_RPAR = 4'd7;
  localparam logic [3:0] OP_MOD  = 4'd8;

  localparam logic [3:0] C_LT = 4'd0;
  localparam logic [3:0] C_LE = 4'd1;
  localparam logic [3:0] C_NE = 4'd2;
  localparam logic [3:0] C_GT = 4'd3;
  localparam logic [3:0] C_GE = 4'd4;
  localparam logic [3:0] C_EQ = 4'd5;

  localparam logic [3:0] CMD_RUN   = 4'd0;
  localparam logic [3:0] CMD_LOAD  = 4'd1;
  localparam logic [3:0] CMD_LIST  = 4'd2;
  localparam logic [3:0] CMD_CLEAR = 4'd3;
  localparam logic [3:0] CMD_HELP  = 4'd4;
  localparam logic [3:0] CMD_QUIT  = 4'd5;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_NUM     = 3'd1;
  localparam logic [2:0] M_WORD    = 3'd2;
  localparam logic [2:0] M_STAR    = 3'd3;
  localparam logic [2:0] M_LESS    = 3'd4;
  localparam logic [2:0] M_GREATER = 3'd5;
  localparam logic [2:0] M_SKIP    = 3'd6;
  localparam logic [2:0] M_STRING  = 3'd7;

  // output phases of one character, in emission order
  localparam int P_PRE  = 0;
  localparam int P_PSTR = 1;
  localparam int P_CHR  = 2;
  localparam int P_END  = 3;
  localparam int P_ESTR = 4;

  typedef struct packed {
    logic [2:0]       kind;
    logic [3:0]       code;
    logic [NUM_W-1:0] number;
    logic [CH_W-1:0]  text_char;
    logic             word_end;
    logic             overflow;
  } tok_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] kind;
    logic [3:0] code;
  } vocab_t;

  typedef struct packed {
    logic           load;
    logic [NPH-1:0] sel;
    logic           step;
  } dp_cmd_t;

  typedef struct packed {
    logic [NPH-1:0] plan_mask;
    logic [NPH-1:0] mask;
    logic           stream_last;
  } dp_status_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
  endfunction

  // key holds the first characters, last one in the low byte
  function automatic vocab_t vocab_lookup(input logic [LEN_W-1:0] n,
                                          input logic [KEY_W-1:0] key);
    vocab_t v;
    v = '0;
    case (n)
      LEN_W'(2): begin
        if (key[15:0] == "IF") v = '{1'b1, K_KEY, KEY_IF};
      end
      LEN_W'(3): begin
        if (key[23:0] == "REM") v = '{1'b1, K_KEY, KEY_REM};
        else if (key[23:0] == "LET") v = '{1'b1, K_KEY, KEY_LET};
        else if (key[23:0] == "END") v = '{1'b1, K_KEY, KEY_END};
        else if (key[23:0] == "MOD") v = '{1'b1, K_OP, OP_MOD};
        else if (key[23:0] == "RUN") v = '{1'b1, K_CMD, CMD_RUN};
      end
      LEN_W'(4): begin
        if (key[31:0] == "GOTO") v = '{1'b1, K_KEY, KEY_GOTO};
        else if (key[31:0] == "THEN") v = '{1'b1, K_KEY, KEY_THEN};
        else if (key[31:0] == "LOAD") v = '{1'b1, K_CMD, CMD_LOAD};
        else if (key[31:0] == "LIST") v = '{1'b1, K_CMD, CMD_LIST};
        else if (key[31:0] == "HELP") v = '{1'b1, K_CMD, CMD_HELP};
        else if (key[31:0] == "QUIT") v = '{1'b1, K_CMD, CMD_QUIT};
      end
      LEN_W'(5): begin
        if (key[39:0] == "PRINT") v = '{1'b1, K_KEY, KEY_PRINT};
        else if (key[39:0] == "INPUT") v = '{1'b1, K_KEY, KEY_INPUT};
        else if (key[39:0] == "CLEAR") v = '{1'b1, K_CMD, CMD_CLEAR};
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/blt_ram.sv @@
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module blt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (we && (waddr == raddr)) rdata <= wdata;
    else rdata <= mem[raddr];
  end

endmodule

@@ sv/blt_ctrl.sv @@
// controller: sequences the output phases of each accepted character
`timescale 1ns / 1ps
module blt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic                m_tlast,
  input  blt_pkg::dp_status_t status,
  output blt_pkg::dp_cmd_t    cmd
);
  import blt_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PRE  = 6'b000010,
    ST_PSTR = 6'b000100,
    ST_CHR  = 6'b001000,
    ST_END  = 6'b010000,
    ST_ESTR = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [NPH-1:0] sel, higher, first_plan, first_high;
  logic accept, hs, is_stream, done;

  assign sel        = state[NPH:1];
  assign higher     = status.mask & ~((sel << 1) - NPH'(1));
  assign first_plan = status.plan_mask & (~status.plan_mask + NPH'(1));
  assign first_high = higher & (~higher + NPH'(1));

  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = (state != ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign hs        = m_tvalid && m_tready;
  assign is_stream = sel[P_PSTR] || sel[P_ESTR];
  assign done      = !is_stream || status.stream_last;
  assign m_tlast   = (higher == '0) && done;

  assign cmd.load = accept;
  assign cmd.sel  = sel;
  assign cmd.step = hs;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (first_plan != '0) state_next = state_t'({first_plan, 1'b0});
        end
      end
      ST_PRE, ST_PSTR, ST_CHR, ST_END, ST_ESTR: begin
        if (hs && done) begin
          if (first_high != '0) state_next = state_t'({first_high, 1'b0});
          else state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

@@ sv/blt_datapath.sv @@
// datapath: scan state, word buffer, planned tokens and output mux
`timescale 1ns / 1ps
module blt_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [blt_pkg::CH_W-1:0]    ch,
  input  logic                        line_end,
  input  blt_pkg::dp_cmd_t            cmd,
  output blt_pkg::dp_status_t         status,
  output logic [blt_pkg::TDATA_W-1:0] m_tdata,
  output logic [2:0]                  m_tuser
);
  import blt_pkg::*;

  logic [2:0]       mode, mode_n;
  logic [NUM_W-1:0] acc, acc_n;
  logic             sat, sat_n;
  logic [LEN_W-1:0] wlen, wlen_n;
  logic [KEY_W-1:0] key, key_n;
  logic             prev, prev_n;
  logic             arem, arem_n;
  logic [NPH-1:0]   mask, pmask;
  tok_t             ta, tb, tc, ta_n, tb_n, tc_n, tout;
  logic [LEN_W-1:0] slen, slen_n;
  logic             sov, sov_n;
  logic [ADDR_W-1:0] idx, idx_next;
  logic             we;
  logic [ADDR_W-1:0] waddr;
  logic [CH_W-1:0]  rdata;
  logic             go, stream_last, in_stream;
  logic [NUM_W+3:0] prod;
  vocab_t           vw, vw2;

  function automatic tok_t mk_tok(input logic [2:0] k, input logic [3:0] cd);
    tok_t t;
    t = '0;
    t.kind = k;
    t.code = cd;
    return t;
  endfunction

  function automatic tok_t mk_const(input logic [NUM_W-1:0] v, input logic ov);
    tok_t t;
    t = '0;
    t.kind = K_CONST;
    t.number = v;
    t.overflow = ov;
    return t;
  endfunction

  function automatic tok_t mk_str(input logic [CH_W-1:0] c, input logic le);
    tok_t t;
    t = '0;
    t.kind = K_STR;
    t.text_char = c;
    t.word_end = le;
    return t;
  endfunction

  assign prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (NUM_W+4)'(ch - "0");
  assign vw   = vocab_lookup(wlen, key);

  always_comb begin
    mode_n = mode;
    acc_n  = acc;
    sat_n  = sat;
    wlen_n = wlen;
    key_n  = key;
    prev_n = prev;
    arem_n = arem;
    ta_n   = '0;
    tb_n   = '0;
    tc_n   = '0;
    pmask  = '0;
    slen_n = slen;
    sov_n  = sov;
    we     = 1'b0;
    waddr  = '0;
    go     = 1'b1;
    vw2    = '0;

    // pending token ended or extended by this character
    case (mode)
      M_SKIP: go = 1'b0;
      M_STRING: begin
        tb_n = mk_str(ch, line_end);
        pmask[P_CHR] = 1'b1;
        go = 1'b0;
      end
      M_NUM: begin
        if (is_digit(ch)) begin
          go = 1'b0;
          if (sat || (prod[NUM_W+3:NUM_W] != '0)) begin
            acc_n = NUM_MAX;
            sat_n = 1'b1;
          end else begin
            acc_n = prod[NUM_W-1:0];
          end
        end else begin
          ta_n = mk_const(acc, sat);
          pmask[P_PRE] = 1'b1;
          prev_n = 1'b1;
        end
      end
      M_WORD: begin
        if (is_letter(ch) || is_digit(ch)) begin
          go = 1'b0;
          if (wlen < LEN_W'(WORD_MAX)) begin
            we = 1'b1;
            waddr = wlen[ADDR_W-1:0];
            wlen_n = wlen + LEN_W'(1);
            if (wlen < LEN_W'(KEY_MAX)) key_n = {key[KEY_W-9:0], ch};
          end else begin
            sat_n = 1'b1;
          end
        end else if (vw.hit && !sat) begin
          ta_n = mk_tok(vw.kind, vw.code);
          pmask[P_PRE] = 1'b1;
          prev_n = 1'b0;
          if ((vw.kind == K_KEY) && (vw.code == KEY_REM)) arem_n = 1'b1;
        end else begin
          pmask[P_PSTR] = 1'b1;
          slen_n = wlen;
          sov_n = sat;
          prev_n = 1'b1;
        end
      end
      M_STAR: begin
        mode_n = M_IDLE;
        pmask[P_PRE] = 1'b1;
        prev_n = 1'b0;
        if (ch == "*") begin
          ta_n = mk_tok(K_OP, OP_POW);
          go = 1'b0;
        end else begin
          ta_n = mk_tok(K_OP, OP_MUL);
        end
      end
      M_LESS: begin
        mode_n = M_IDLE;
        pmask[P_PRE] = 1'b1;
        prev_n = 1'b0;
        if (ch == "=") begin
          ta_n = mk_tok(K_CMP, C_LE);
          go = 1'b0;
        end else if (ch == ">") begin
          ta_n = mk_tok(K_CMP, C_NE);
          go = 1'b0;
        end else begin
          ta_n = mk_tok(K_CMP, C_LT);
        end
      end
      M_GREATER: begin
        mode_n = M_IDLE;
        pmask[P_PRE] = 1'b1;
        prev_n = 1'b0;
        if (ch == "=") begin
          ta_n = mk_tok(K_CMP, C_GE);
          go = 1'b0;
        end else begin
          ta_n = mk_tok(K_CMP, C_GT);
        end
      end
      default: go = 1'b1;
    endcase

    // character starts something new
    if (go) begin
      mode_n = M_IDLE;
      if (arem_n) begin
        if (ch != " ") begin
          arem_n = 1'b0;
          mode_n = M_STRING;
          tb_n = mk_str(ch, line_end);
          pmask[P_CHR] = 1'b1;
        end
      end else if (ch == " ") begin
        mode_n = M_IDLE;
      end else if (is_digit(ch)) begin
        acc_n = NUM_W'(ch - "0");
        sat_n = 1'b0;
        mode_n = M_NUM;
      end else if (is_letter(ch)) begin
        we = 1'b1;
        waddr = '0;
        wlen_n = LEN_W'(1);
        key_n = KEY_W'(ch);
        sat_n = 1'b0;
        mode_n = M_WORD;
      end else begin
        case (ch)
          "+": begin
            tb_n = mk_tok(K_OP, OP_ADD);
            pmask[P_CHR] = 1'b1;
            prev_n = 1'b0;
          end
          "-": begin
            tb_n = mk_tok(K_OP, prev_n ? OP_SUB : OP_NEG);
            pmask[P_CHR] = 1'b1;
            prev_n = 1'b0;
          end
          "/": begin
            tb_n = mk_tok(K_OP, OP_DIV);
            pmask[P_CHR] = 1'b1;
            prev_n = 1'b0;
          end
          "(": begin
            tb_n = mk_tok(K_OP, OP_LPAR);
            pmask[P_CHR] = 1'b1;
            prev_n = 1'b0;
          end
          ")": begin
            tb_n = mk_tok(K_OP, OP_RPAR);
            pmask[P_CHR] = 1'b1;
            prev_n = 1'b1;
          end
          "=": begin
            tb_n = mk_tok(K_CMP, C_EQ);
            pmask[P_CHR] = 1'b1;
            prev_n = 1'b0;
          end
          "*": mode_n = M_STAR;
          "<": mode_n = M_LESS;
          ">": mode_n = M_GREATER;
          default: begin
            tb_n = mk_tok(K_ERR, 4'd0);
            pmask[P_CHR] = 1'b1;
            mode_n = M_SKIP;
          end
        endcase
      end
    end

    // line end flushes what is pending and clears the line state
    if (line_end) begin
      vw2 = vocab_lookup(wlen_n, key_n);
      case (mode_n)
        M_NUM: begin
          tc_n = mk_const(acc_n, sat_n);
          pmask[P_END] = 1'b1;
        end
        M_WORD: begin
          if (vw2.hit && !sat_n) begin
            tc_n = mk_tok(vw2.kind, vw2.code);
            pmask[P_END] = 1'b1;
          end else begin
            slen_n = wlen_n;
            sov_n = sat_n;
            pmask[P_ESTR] = 1'b1;
          end
        end
        M_STAR: begin
          tc_n = mk_tok(K_OP, OP_MUL);
          pmask[P_END] = 1'b1;
        end
        M_LESS: begin
          tc_n = mk_tok(K_CMP, C_LT);
          pmask[P_END] = 1'b1;
        end
        M_GREATER: begin
          tc_n = mk_tok(K_CMP, C_GT);
          pmask[P_END] = 1'b1;
        end
        default: pmask[P_END] = 1'b0;
      endcase
      mode_n = M_IDLE;
      acc_n  = '0;
      sat_n  = 1'b0;
      wlen_n = '0;
      key_n  = '0;
      prev_n = 1'b0;
      arem_n = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      acc  <= '0;
      sat  <= 1'b0;
      wlen <= '0;
      key  <= '0;
      prev <= 1'b0;
      arem <= 1'b0;
      mask <= '0;
    end else if (cmd.load) begin
      mode <= mode_n;
      acc  <= acc_n;
      sat  <= sat_n;
      wlen <= wlen_n;
      key  <= key_n;
      prev <= prev_n;
      arem <= arem_n;
      mask <= pmask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ta   <= ta_n;
      tb   <= tb_n;
      tc   <= tc_n;
      slen <= slen_n;
      sov  <= sov_n;
    end
  end

  // identifier stream: the ram is read at the next index, so its registered output shows the current entry
  assign in_stream   = cmd.sel[P_PSTR] || cmd.sel[P_ESTR];
  assign stream_last = ((LEN_W'(idx) + LEN_W'(1)) == slen);

  always_comb begin
    idx_next = idx;
    if (cmd.load) idx_next = '0;
    else if (cmd.step && in_stream && !stream_last) idx_next = idx + ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else idx <= idx_next;
  end

  blt_ram #(
    .WIDTH(CH_W),
    .DEPTH(WORD_MAX)
  ) u_word_ram (
    .clk  (clk),
    .we   (we && cmd.load),
    .waddr(waddr),
    .wdata(ch),
    .raddr(idx_next),
    .rdata(rdata)
  );

  always_comb begin
    tout = '0;
    if (in_stream) begin
      tout.kind = K_IDENT;
      tout.text_char = rdata;
      tout.word_end = stream_last;
      tout.overflow = sov;
    end else if (cmd.sel[P_PRE]) begin
      tout = ta;
    end else if (cmd.sel[P_CHR]) begin
      tout = tb;
    end else if (cmd.sel[P_END]) begin
      tout = tc;
    end
  end

  assign m_tuser = tout.kind;
  assign m_tdata = {3'b000, tout.overflow, tout.word_end, tout.text_char,
                    tout.number, tout.code};

  assign status.plan_mask   = pmask;
  assign status.mask        = mask;
  assign status.stream_last = stream_last;

endmodule

@@ sv/basic_line_tokenizer.sv @@
// top level of the line tokenizer: controller plus datapath
//
//  port group  dir  carries
//  s_*         in   one character a beat, tlast on the last one of the line
//  m_*         out  one token a beat, tuser = kind, tlast on the last of a character
//
// one character is taken per cycle when it produces no token
// a character producing tokens holds the input until its last token is taken, one token a beat
// an identifier runs one beat per buffered character, up to 32, read from the word ram
// output stalls hold the token and the input; nothing is accepted while tokens remain
// synchronous reset returns the scanner to the start of a line
`timescale 1ns / 1ps
module basic_line_tokenizer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // ch
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [blt_pkg::TDATA_W-1:0] m_tdata,  // code, number, text_char, word_end, overflow
  output logic [2:0]                  m_tuser,  // kind
  output logic                        m_tlast
);
  import blt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  blt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tlast (m_tlast),
    .status  (status),
    .cmd     (cmd)
  );

  blt_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .ch      (s_tdata),
    .line_end(s_tlast),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

@@ sv/blt_checker.sv @@
// port checker for the line tokenizer and its bind
`timescale 1ns / 1ps
`include "basic_line_tokenizer_defines.svh"
module blt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [7:0]                  s_tdata,
  input logic                        s_tlast,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [blt_pkg::TDATA_W-1:0] m_tdata,
  input logic [2:0]                  m_tuser,
  input logic                        m_tlast
);
  import blt_pkg::*;

  `BLT_ASSERT_IMPL(a_one_side, s_tready, !m_tvalid, "input open while tokens pending")
  `BLT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")
  `BLT_ASSERT_NEXT(a_idle_after_last, m_tvalid && m_tready && m_tlast, s_tready, "not ready after last beat")
  `BLT_ASSERT_IMPL(a_err_blank, m_tvalid && (m_tuser == K_ERR), m_tdata == '0, "error beat carries data")

endmodule

bind basic_line_tokenizer blt_checker u_blt_checker (.*);

@@ verif/basic_line_tokenizer_checker.sv @@
// checker for the line tokenizer: predicts tokens per accepted character and compares
`timescale 1ns / 1ps
module basic_line_tokenizer_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [7:0]                  s_tdata,
  input  logic                        s_tlast,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [blt_pkg::TDATA_W-1:0] m_tdata,
  input  logic [2:0]                  m_tuser,
  input  logic                        m_tlast,
  output int                          err_count,
  output int                          pending
);
  import blt_pkg::*;

  typedef struct packed {
    logic [2:0]       kind;
    logic [3:0]       code;
    logic [NUM_W-1:0] number;
    logic [7:0]       text_char;
    logic             word_end;
    logic             overflow;
    logic             last;
  } token_t;

  token_t tok_q[$];

  logic [2:0]       mode;
  logic [NUM_W-1:0] acc;
  logic             sat;
  logic [7:0]       wbuf [WORD_MAX];
  int               wlen;
  logic             prev_val;
  logic             rem_seen;
  token_t           step_toks[$];

  assign pending = tok_q.size();

  function automatic logic digit_c(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic letter_c(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) || c == 8'h5f;
  endfunction

  task automatic push_tok(logic [2:0] k, logic [3:0] cd, logic [NUM_W-1:0] n,
                          logic [7:0] tc, logic we, logic ov);
    token_t t;
    t = '{k, cd, n, tc, we, ov, 1'b0};
    step_toks.push_back(t);
  endtask

  task automatic push_op(logic [3:0] cd);
    push_tok(K_OP, cd, '0, 8'd0, 1'b0, 1'b0);
    prev_val = (cd == OP_RPAR);
  endtask

  task automatic push_cmp(logic [3:0] cd);
    push_tok(K_CMP, cd, '0, 8'd0, 1'b0, 1'b0);
    prev_val = 1'b0;
  endtask

  task automatic emit_number();
    push_tok(K_CONST, 4'd0, acc, 8'd0, 1'b0, sat);
    prev_val = 1'b1;
  endtask

  task automatic emit_word();
    string w;
    logic hit;
    logic [2:0] k;
    logic [3:0] cd;
    w = "";
    hit = 1'b0;
    k = K_KEY;
    cd = 4'd0;
    for (int i = 0; i < wlen; i++) w = {w, string'(wbuf[i])};
    if (!sat) begin
      hit = 1'b1;
      case (w)
        "REM":   begin k = K_KEY; cd = KEY_REM;   end
        "LET":   begin k = K_KEY; cd = KEY_LET;   end
        "PRINT": begin k = K_KEY; cd = KEY_PRINT; end
        "INPUT": begin k = K_KEY; cd = KEY_INPUT; end
        "GOTO":  begin k = K_KEY; cd = KEY_GOTO;  end
        "IF":    begin k = K_KEY; cd = KEY_IF;    end
        "THEN":  begin k = K_KEY; cd = KEY_THEN;  end
        "END":   begin k = K_KEY; cd = KEY_END;   end
        "MOD":   begin k = K_OP;  cd = OP_MOD;    end
        "RUN":   begin k = K_CMD; cd = CMD_RUN;   end
        "LOAD":  begin k = K_CMD; cd = CMD_LOAD;  end
        "LIST":  begin k = K_CMD; cd = CMD_LIST;  end
        "CLEAR": begin k = K_CMD; cd = CMD_CLEAR; end
        "HELP":  begin k = K_CMD; cd = CMD_HELP;  end
        "QUIT":  begin k = K_CMD; cd = CMD_QUIT;  end
        default: hit = 1'b0;
      endcase
    end
    if (hit) begin
      push_tok(k, cd, '0, 8'd0, 1'b0, 1'b0);
      prev_val = 1'b0;
      if (k == K_KEY && cd == KEY_REM) rem_seen = 1'b1;
    end else begin
      for (int i = 0; i < wlen; i++)
        push_tok(K_IDENT, 4'd0, '0, wbuf[i], i + 1 == wlen, sat);
      prev_val = 1'b1;
    end
  endtask

  task automatic scan_char(logic [7:0] c, logic le);
    logic [NUM_W-1:0] d;
    case (mode)
      M_SKIP: return;
      M_STRING: begin
        push_tok(K_STR, 4'd0, '0, c, le, 1'b0);
        return;
      end
      M_NUM: begin
        if (digit_c(c)) begin
          d = NUM_W'(c - 8'h30);
          if (sat || acc > (NUM_MAX - d) / 10) begin
            acc = NUM_MAX;
            sat = 1'b1;
          end else acc = acc * 10 + d;
          return;
        end
        emit_number();
      end
      M_WORD: begin
        if (letter_c(c) || digit_c(c)) begin
          if (wlen < WORD_MAX) begin
            wbuf[wlen] = c;
            wlen++;
          end else sat = 1'b1;
          return;
        end
        emit_word();
      end
      M_STAR: begin
        mode = M_IDLE;
        if (c == "*") begin push_op(OP_POW); return; end
        push_op(OP_MUL);
      end
      M_LESS: begin
        mode = M_IDLE;
        if (c == "=") begin push_cmp(C_LE); return; end
        if (c == ">") begin push_cmp(C_NE); return; end
        push_cmp(C_LT);
      end
      M_GREATER: begin
        mode = M_IDLE;
        if (c == "=") begin push_cmp(C_GE); return; end
        push_cmp(C_GT);
      end
      default: ;
    endcase
    mode = M_IDLE;
    if (rem_seen) begin
      if (c == " ") return;
      rem_seen = 1'b0;
      mode = M_STRING;
      push_tok(K_STR, 4'd0, '0, c, le, 1'b0);
      return;
    end
    if (c == " ") return;
    if (digit_c(c)) begin
      acc = NUM_W'(c - 8'h30);
      sat = 1'b0;
      mode = M_NUM;
      return;
    end
    if (letter_c(c)) begin
      wbuf[0] = c;
      wlen = 1;
      sat = 1'b0;
      mode = M_WORD;
      return;
    end
    case (c)
      "+": push_op(OP_ADD);
      "-": push_op(prev_val ? OP_SUB : OP_NEG);
      "/": push_op(OP_DIV);
      "(": push_op(OP_LPAR);
      ")": push_op(OP_RPAR);
      "=": push_cmp(C_EQ);
      "*": mode = M_STAR;
      "<": mode = M_LESS;
      ">": mode = M_GREATER;
      default: begin
        push_tok(K_ERR, 4'd0, '0, 8'd0, 1'b0, 1'b0);
        mode = M_SKIP;
      end
    endcase
  endtask

  task automatic predict_tokens(logic [7:0] c, logic le);
    step_toks.delete();
    scan_char(c, le);
    if (le) begin
      case (mode)
        M_NUM:     emit_number();
        M_WORD:    emit_word();
        M_STAR:    push_op(OP_MUL);
        M_LESS:    push_cmp(C_LT);
        M_GREATER: push_cmp(C_GT);
        default: ;
      endcase
      mode = M_IDLE;
      acc = '0;
      sat = 1'b0;
      wlen = 0;
      prev_val = 1'b0;
      rem_seen = 1'b0;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) tok_q.push_back(step_toks[i]);
  endtask

  always @(posedge clk) begin
    token_t got, exp_tok;
    if (rst) begin
      mode = M_IDLE;
      acc = '0;
      sat = 1'b0;
      wlen = 0;
      prev_val = 1'b0;
      rem_seen = 1'b0;
      tok_q.delete();
      err_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tuser, m_tdata[3:0], m_tdata[66:4], m_tdata[74:67], m_tdata[75],
                m_tdata[76], m_tlast};
        if (tok_q.size() == 0) begin
          if (err_count < 10) $display("unexpected token beat %h", got);
          err_count <= err_count + 1;
        end else begin
          exp_tok = tok_q.pop_front();
          if (got !== exp_tok) begin
            if (err_count < 10)
              $display("token mismatch: expected %h actual %h", exp_tok, got);
            err_count <= err_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) predict_tokens(s_tdata, s_tlast);
    end
  end
endmodule

@@ verif/basic_line_tokenizer_tb.sv @@
// testbench top for the line tokenizer: character stimulus and verdict
`timescale 1ns / 1ps
module basic_line_tokenizer_tb;
  import blt_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [TDATA_W-1:0]   m_tdata;
  logic [2:0]           m_tuser;
  logic                 m_tlast;
  int                   err_count;
  int                   pending;
  int                   send_idle;
  int                   recv_idle;

  basic_line_tokenizer dut (.*);

  basic_line_tokenizer_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

  task automatic send_char(logic [7:0] c, logic le);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= le;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic string rand_word();
    string s;
    string pool[$];
    pool = '{"REM", "LET", "PRINT", "INPUT", "GOTO", "IF", "THEN", "END", "MOD",
             "RUN", "LOAD", "LIST", "CLEAR", "HELP", "QUIT", "x", "Ab_9", "rem"};
    if ($urandom_range(3) != 0) return pool[$urandom_range(pool.size() - 1)];
    s = "";
    for (int i = $urandom_range(1, 5); i > 0; i--)
      s = {s, string'(8'($urandom_range(0, 1) ? $urandom_range(65, 90) : $urandom_range(97, 122)))};
    return s;
  endfunction

  function automatic string rand_token();
    string ops[$];
    string s;
    ops = '{"+", "-", "*", "**", "/", "(", ")", "<", "<=", "<>", ">", ">=", "=", " "};
    case ($urandom_range(9))
      0, 1, 2: return rand_word();
      3, 4: begin
        s = "";
        for (int i = $urandom_range(1, 4); i > 0; i--)
          s = {s, string'(8'($urandom_range(48, 57)))};
        return s;
      end
      5: return string'(8'($urandom_range(255)));
      default: return ops[$urandom_range(ops.size() - 1)];
    endcase
  endfunction

  task automatic random_line();
    string s;
    s = "";
    for (int i = $urandom_range(1, 5); i > 0; i--) begin
      s = {s, rand_token()};
      if ($urandom_range(1)) s = {s, " "};
    end
    send_line(s);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    s_tlast = 1'b0;
    send_idle = 26;
    recv_idle = 47;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed lines
    send_line("-9223372036854775807-99999999999999999999)-x");
    send_line("REM  hi");
    send_line("LET a_Z9 = 1**2*3<=4<>5>=6<7>8/(9)");
    send_line("abcdefghijklmnopqrstuvwxyz0123456789 MOD");
    send_line("PRINT INPUT GOTO IF THEN END RUN LOAD LIST CLEAR HELP QUIT");
    send_line("REM");
    send_line("1 $ foo");
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b1);
    send_line("a<");
    send_line("b>");
    send_line("c*");
    // all to drain before continuing
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 26 : (ph == 1) ? 47 : 0;
      recv_idle = (ph == 0) ? 47 : (ph == 1) ? 26 : 0;
      for (int n = 0; n < 7; n++) random_line();
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
